/* design/dlrg_pkg.sv */
// Package for the dense layer with ReLU/GELU activation.
// Payload structs, register indexes, action codes and the tanh table.
// No dependencies.
package dlrg_pkg;

  localparam int MAX_IN    = 64;
  localparam int MAX_OUT   = 16;
  localparam int DATA_BITS = 16;
  localparam int ACC_BITS  = 40;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 4;
  localparam int WADDR_W   = ROW_W + COL_W;

  localparam logic [1:0] ACT_WEIGHT = 2'd0;
  localparam logic [1:0] ACT_BIAS   = 2'd1;
  localparam logic [1:0] ACT_ELEM   = 2'd2;

  localparam logic [1:0] REG_IN_SIZE  = 2'd0;
  localparam logic [1:0] REG_OUT_SIZE = 2'd1;
  localparam logic [1:0] REG_ACT_MODE = 2'd2;

  typedef struct packed {
    logic [1:0]                  action;
    logic [ROW_W-1:0]            row_pos;
    logic [COL_W-1:0]            col_pos;
    logic signed [DATA_BITS-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [COL_W-1:0]            out_pos;
    logic signed [DATA_BITS-1:0] out_value;
    logic                        is_last;
  } out_word_t;

  // controller -> datapath commands
  typedef struct packed {
    logic             latch_in;   // capture input word
    logic             mac;        // issue weight/bias read for column col
    logic             act;        // issue accumulator read for column col
    logic [COL_W-1:0] col;
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic busy;       // pipeline still has ops in flight
    logic out_valid;  // output register full
  } dp_sts_t;

  function automatic logic [16:0] tanh_tab(input logic [4:0] i);
    case (i)
      5'd0:  tanh_tab = 17'd0;
      5'd1:  tanh_tab = 17'd16051;
      5'd2:  tanh_tab = 17'd30285;
      5'd3:  tanh_tab = 17'd41625;
      5'd4:  tanh_tab = 17'd49912;
      5'd5:  tanh_tab = 17'd55593;
      5'd6:  tanh_tab = 17'd59320;
      5'd7:  tanh_tab = 17'd61694;
      5'd8:  tanh_tab = 17'd63179;
      5'd9:  tanh_tab = 17'd64096;
      5'd10: tanh_tab = 17'd64659;
      5'd11: tanh_tab = 17'd65000;
      5'd12: tanh_tab = 17'd65212;
      5'd13: tanh_tab = 17'd65340;
      5'd14: tanh_tab = 17'd65417;
      5'd15: tanh_tab = 17'd65464;
      5'd16: tanh_tab = 17'd65492;
      default: tanh_tab = 17'd65536;
    endcase
  endfunction

endpackage

/* design/dlrg_ctrl.sv */
// Controller for the dense layer: walks columns for MAC and activation passes.
// Depends on dlrg_pkg.
module dlrg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dlrg_pkg::in_word_t  in_data,
  input  logic [6:0]          n_in,
  input  logic [4:0]          n_out,
  output dlrg_pkg::dp_cmd_t   cmd,
  input  dlrg_pkg::dp_sts_t   sts
);
  import dlrg_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MAC, S_DRAIN, S_ACT} state_t;

  state_t           state_r, state_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             rel_r, rel_nxt;
  logic             acc_in;
  logic [COL_W-1:0] last_col;

  assign last_col = n_out[COL_W-1:0] - 1'b1;
  assign in_ready = (state_r == S_IDLE);
  assign acc_in   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    rel_nxt      = rel_r;
    cmd          = '0;
    cmd.col      = col_r;
    cmd.latch_in = acc_in;
    case (state_r)
      S_IDLE: begin
        if (acc_in && in_data.action == ACT_ELEM &&
            {1'b0, in_data.row_pos} < n_in) begin
          state_nxt = S_MAC;
          col_nxt   = '0;
          rel_nxt   = ({1'b0, in_data.row_pos} == n_in - 7'd1);
        end
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        col_nxt = col_r + 1'b1;
        if (col_r == last_col) begin
          col_nxt   = '0;
          state_nxt = rel_r ? S_DRAIN : S_IDLE;
        end
      end
      S_DRAIN: begin
        if (!sts.busy) state_nxt = S_ACT;
      end
      S_ACT: begin
        if (!sts.busy && !sts.out_valid) begin
          cmd.act = 1'b1;
          col_nxt = col_r + 1'b1;
          if (col_r == last_col) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      rel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      rel_r   <= rel_nxt;
    end
  end
endmodule

/* design/dlrg_dp.sv */
// Datapath: weight/bias stores, shared MAC, accumulators, activation pipeline.
// Depends on dlrg_pkg.
module dlrg_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  dlrg_pkg::in_word_t  in_data,
  input  logic [4:0]          n_out,
  input  logic                act_mode,
  input  dlrg_pkg::dp_cmd_t   cmd,
  output dlrg_pkg::dp_sts_t   sts,
  output logic                out_valid,
  input  logic                out_ready,
  output dlrg_pkg::out_word_t out_data
);
  import dlrg_pkg::*;

  logic [DATA_BITS-1:0] wmem [MAX_IN*MAX_OUT];
  logic [DATA_BITS-1:0] bmem [MAX_OUT];
  logic [ACC_BITS-1:0]  acc_r [MAX_OUT];

  in_word_t             word_r;
  logic [DATA_BITS-1:0] wrd_r, brd_r;
  // pipeline valids
  logic                 m1_r, m2_r, a1_r, a2_r, a3_r, a4_r, a5_r, a6_r;
  logic [COL_W-1:0]     m1c_r, m2c_r, a1c_r, a2c_r, a3c_r, a4c_r, a5c_r, a6c_r;
  logic signed [31:0]   prod_r;
  logic                 seed1_r, seed2_r;
  logic signed [ACC_BITS-1:0] bseed_r;
  logic signed [DATA_BITS-1:0] x1_r, x2_r, x3_r, x4_r, x5_r;
  logic [ACC_BITS-1:0]  ard_r;
  logic signed [31:0]   xx_r;
  logic signed [47:0]   x3v_r;
  logic signed [47:0]   u_r;
  logic signed [47:0]   a_r;
  logic signed [17:0]   t_r;
  logic                 ov_r;
  out_word_t            od_r;

  // ---- stores ----
  always_ff @(posedge clk) begin
    if (cmd.latch_in && in_data.action == ACT_WEIGHT)
      wmem[{in_data.row_pos, in_data.col_pos}] <= in_data.value;
    if (cmd.latch_in && in_data.action == ACT_BIAS)
      bmem[in_data.col_pos] <= in_data.value;
    if (cmd.mac) begin
      wrd_r <= wmem[{word_r.row_pos, cmd.col}];
      brd_r <= bmem[cmd.col];
    end
    if (cmd.latch_in) word_r <= in_data;
  end

  // ---- MAC: read -> multiply -> accumulate ----
  always_ff @(posedge clk) begin
    prod_r  <= $signed(word_r.value) * $signed(wrd_r);
    bseed_r <= ACC_BITS'($signed(brd_r)) <<< 8;
    seed1_r <= (word_r.row_pos == '0);
    seed2_r <= seed1_r;
    m1c_r   <= cmd.col;
    m2c_r   <= m1c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_OUT; i++) acc_r[i] <= '0;
    end else if (m2_r) begin
      acc_r[m2c_r] <= (seed2_r ? bseed_r : acc_r[m2c_r]) + ACC_BITS'(prod_r);
    end
  end

  // ---- activation pipeline ----
  logic signed [ACC_BITS:0] rnd;
  logic signed [32:0]       sh;
  logic signed [DATA_BITS-1:0] xs;
  assign rnd = $signed({ard_r[ACC_BITS-1], ard_r}) + 41'sd128;
  assign sh  = rnd[ACC_BITS:8];
  assign xs  = (sh > 33'sd32767) ? 16'sh7fff :
               (sh < -33'sd32768) ? 16'sh8000 : DATA_BITS'(sh);

  // tanh lookup from a_r
  logic [47:0] mag;
  logic [16:0] tb0, tb1, tmag;
  logic [34:0] dprod;
  assign mag   = a_r[47] ? 48'(-a_r) : 48'(a_r);
  assign tb0   = tanh_tab({1'b0, mag[17:14]});
  assign tb1   = tanh_tab({1'b0, mag[17:14]} + 5'd1);
  assign dprod = 35'(tb1 - tb0) * 35'(mag[13:0]);
  assign tmag  = (mag >= 48'd262144) ? 17'd65536 : tb0 + 17'(dprod >> 14);

  logic signed [49:0] gp;
  logic signed [32:0] gs;
  logic signed [DATA_BITS-1:0] gel, relu;
  assign gp   = $signed(x5_r) * ($signed(t_r) + 50'sd65536) + 50'sd65536;
  assign gs   = gp[49:17];
  assign gel  = (gs > 33'sd32767) ? 16'sh7fff :
                (gs < -33'sd32768) ? 16'sh8000 : DATA_BITS'(gs);
  assign relu = x5_r[DATA_BITS-1] ? '0 : x5_r;

  // x_k holds x at stage k; cube term products are taken at 64 bits
  always_ff @(posedge clk) begin
    if (cmd.act) ard_r <= acc_r[cmd.col];
    a1c_r <= cmd.col;
    a2c_r <= a1c_r; a3c_r <= a2c_r; a4c_r <= a3c_r; a5c_r <= a4c_r;
    a6c_r <= a5c_r;
    x1_r  <= xs;
    xx_r  <= $signed(xs) * $signed(xs);
    x2_r  <= x1_r;
    x3v_r <= 48'($signed(xx_r) * $signed(x1_r));
    x3_r  <= x2_r;
    u_r   <= (48'($signed(x2_r)) <<< 8) + 48'((64'(x3v_r) * 64'sd2930) >>> 24);
    x4_r  <= x3_r;
    a_r   <= 48'((64'(u_r) * 64'sd52290) >>> 16);
    x5_r  <= x4_r;
    t_r   <= a_r[47] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
  end

  // valids; final stage lands in output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r <= 1'b0; m2_r <= 1'b0;
      a1_r <= 1'b0; a2_r <= 1'b0; a3_r <= 1'b0; a4_r <= 1'b0; a5_r <= 1'b0;
      a6_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      m1_r <= cmd.mac; m2_r <= m1_r;
      a1_r <= cmd.act; a2_r <= a1_r; a3_r <= a2_r; a4_r <= a3_r; a5_r <= a4_r;
      a6_r <= a5_r;
      if (a6_r) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a6_r) begin
      od_r.out_pos   <= a6c_r;
      od_r.out_value <= act_mode ? gel : relu;
      od_r.is_last   <= (a6c_r == n_out[COL_W-1:0] - 1'b1);
    end
  end

  assign sts.busy      = m1_r | m2_r | a1_r | a2_r | a3_r | a4_r | a5_r | a6_r;
  assign sts.out_valid = ov_r;
  assign out_valid     = ov_r;
  assign out_data      = od_r;
endmodule

/* design/dense_layer_relu_gelu_top.sv */
// Top level of the dense layer with ReLU/GELU activation.
// Depends on dlrg_pkg, dlrg_ctrl, dlrg_dp.
//
//  channel | ports                       | direction
//  --------+-----------------------------+----------
//  input   | in_valid/in_ready/in_data   | in  (one word per item)
//  result  | out_valid/out_ready/out_data| out (one word per output)
//  config  | cfg_valid/cfg_ready/cfg_*   | in  (register writes)
//
// Weight and bias words are written to the stores as they are accepted. A row
// element is accepted and then uses the shared multiply-accumulate unit for
// each output column, one column per cycle. The row's last element then drains
// the MAC pipeline and runs each column through a 6-stage activation pipeline one
// at a time: a column waits until the pipeline is empty and the last result is taken.
// Reset (synchronous, active low) clears the accumulators and resets control,
// valid and config registers; the stores hold garbage until written.
module dense_layer_relu_gelu_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dlrg_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dlrg_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data
);
  import dlrg_pkg::*;

  logic [6:0] in_size_r;
  logic [4:0] out_size_r;
  logic       act_mode_r;
  logic [6:0] n_in;
  logic [4:0] n_out;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_size_r  <= 7'd64;
      out_size_r <= 5'd16;
      act_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IN_SIZE:  in_size_r  <= cfg_data;
        REG_OUT_SIZE: out_size_r <= cfg_data[4:0];
        REG_ACT_MODE: act_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp sizes into 1..MAX
  assign n_in  = (in_size_r == '0) ? 7'd1 :
                 (in_size_r > 7'(MAX_IN)) ? 7'(MAX_IN) : in_size_r;
  assign n_out = (out_size_r == '0) ? 5'd1 :
                 (out_size_r > 5'(MAX_OUT)) ? 5'(MAX_OUT) : out_size_r;

  dlrg_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .n_in, .n_out, .cmd, .sts
  );

  dlrg_dp u_dp (
    .clk, .rst_n, .in_data, .n_out, .act_mode(act_mode_r),
    .cmd, .sts, .out_valid, .out_ready, .out_data
  );
endmodule

/* dv/dlrg_checker.sv */
// Checker for the dense layer: watches config, input and result channels,
// predicts the result words and compares them field by field.
// Depends on dlrg_pkg.
module dlrg_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  dlrg_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  dlrg_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data,
  output int                  n_fail,
  output int                  n_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import dlrg_pkg::*;

  logic [15:0]       wt_mem [MAX_IN*MAX_OUT];
  logic [15:0]       bias_mem [MAX_OUT];
  logic [39:0]       acc_q [MAX_OUT];
  logic [6:0]        in_size_q;
  logic [4:0]        out_size_q;
  logic              gelu_q;
  out_word_t         expected_q[$];

  function automatic longint floor_div(longint v, int s);
    return v >>> s;  // arithmetic shift is floor
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint tanh_fix(longint a);
    longint m, t, d, lo;
    int i;
    m = (a < 0) ? -a : a;
    if (m >= (64'sd1 << 18)) begin
      t = 65536;
    end else begin
      i = int'(m >> 14);
      lo = longint'(tanh_tab(i[4:0]));
      d = longint'(tanh_tab(i[4:0] + 5'd1)) - lo;
      t = lo + ((d * (m & 'h3FFF)) >> 14);
    end
    return (a < 0) ? -t : t;
  endfunction

  function automatic longint gelu_fix(longint x);
    longint u, a;
    u = x * 256 + floor_div(x * x * x * 2930, 24);
    a = floor_div(u * 52290, 16);
    return clip16(floor_div(x * (65536 + tanh_fix(a)) + 65536, 17));
  endfunction

  task automatic predict_word(in_word_t w);
    int n_in, n_out;
    longint a, x, y;
    out_word_t r;
    n_in = (in_size_q == 0) ? 1 : (in_size_q > MAX_IN) ? MAX_IN : in_size_q;
    n_out = (out_size_q == 0) ? 1 : (out_size_q > MAX_OUT) ? MAX_OUT : out_size_q;
    case (w.action)
      ACT_WEIGHT: wt_mem[{w.row_pos, w.col_pos}] = w.value;
      ACT_BIAS:   bias_mem[w.col_pos] = w.value;
      ACT_ELEM: begin
        if (w.row_pos < n_in) begin
          for (int o = 0; o < n_out; o++) begin
            if (w.row_pos == 0)
              acc_q[o] = 40'(longint'($signed(bias_mem[o])) * 256);
            acc_q[o] = acc_q[o] + 40'(longint'(w.value) *
                       longint'($signed(wt_mem[{w.row_pos, 4'(o)}])));
          end
          if (w.row_pos == n_in - 1) begin
            for (int o = 0; o < n_out; o++) begin
              a = longint'($signed(acc_q[o]));
              x = clip16(floor_div(a + 128, 8));
              y = gelu_q ? gelu_fix(x) : ((x < 0) ? 0 : x);
              r.out_pos = 4'(o);
              r.out_value = 16'(y);
              r.is_last = (o == n_out - 1);
              expected_q.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      for (int o = 0; o < MAX_OUT; o++) acc_q[o] = '0;
      in_size_q <= 7'd64;
      out_size_q <= 5'd16;
      gelu_q <= 1'b0;
      n_fail = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IN_SIZE:  in_size_q <= cfg_data;
          REG_OUT_SIZE: out_size_q <= cfg_data[4:0];
          REG_ACT_MODE: gelu_q <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_word(in_data);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected result word %p", out_data);
        end else begin
          e = expected_q.pop_front();
          if (out_data.out_pos !== e.out_pos || out_data.out_value !== e.out_value ||
              out_data.is_last !== e.is_last) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch: exp pos %0d val %0d last %0b, got pos %0d val %0d last %0b",
                       e.out_pos, e.out_value, e.is_last, out_data.out_pos,
                       out_data.out_value, out_data.is_last);
          end
        end
      end
    end
    n_pending = expected_q.size();
  end
endmodule

/* dv/tb_top.sv */
// Testbench top for the dense layer: clock, reset, config and input stimulus,
// result-side stalls, verdict. Depends on dlrg_pkg, dlrg_checker and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dlrg_pkg::*;

  localparam int LIMIT = 20000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic      clk, rst_n;
  logic      in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_word_t  in_data;
  out_word_t out_data;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;
  int n_fail, n_pending;
  bit calm;               // no idling in the last part of the run
  int n_in, n_out;        // current row shape, mirrored for stimulus
  int quiet = 0;          // watchdog: cycles with nothing accepted

  dense_layer_relu_gelu_top i_dut (.*);

  dlrg_checker i_chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Receiver: random bursts of stalls, none once calm.
  initial begin
    int burst;
    burst = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        burst--;
        out_ready = 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(0, 17);
        out_ready = 0;
      end else begin
        out_ready = 1;
      end
    end
  end

  // Watchdog: counts cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > LIMIT) begin
      $display("FAIL dense_layer_relu_gelu_top");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [6:0] v);
    cfg_index = idx;
    cfg_data = v;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Send one word, with an optional random gap ahead of it.
  task automatic send(logic [1:0] act, int row, int col, logic [15:0] v);
    if (!calm && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_data = '{action: act, row_pos: 6'(row), col_pos: 4'(col), value: v};
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 0;
  endtask

  // Wait until no result is expected, then let the pipeline settle.
  task automatic drain();
    while (n_pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [15:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // Load every weight and bias the current shape reads, then random rows.
  // sparse: only the first and last row positions carry weights and elements.
  task automatic run_phase(int isz, int osz, bit gelu, int rows, bit big, bit sparse);
    cfg_write(REG_IN_SIZE, 7'(isz));
    cfg_write(REG_OUT_SIZE, 7'(osz));
    cfg_write(REG_ACT_MODE, 7'(gelu));
    n_in = (isz == 0) ? 1 : (isz > MAX_IN ? MAX_IN : isz);
    n_out = (osz == 0) ? 1 : (osz > MAX_OUT ? MAX_OUT : osz);
    for (int o = 0; o < n_out; o++) send(ACT_BIAS, $urandom_range(0, 63), o, rnd_val());
    for (int r = 0; r < n_in; r++) begin
      if (sparse && r != 0 && r != n_in - 1) continue;
      for (int o = 0; o < n_out; o++)
        send(ACT_WEIGHT, r, o, big ? rnd_val() : 16'(int'($urandom_range(0, 255)) - 128));
    end
    for (int k = 0; k < rows; k++) begin
      for (int r = 0; r < n_in; r++) begin
        if (sparse && r != 0 && r != n_in - 1) continue;
        // occasional noise: unused action or element beyond the row
        if ($urandom_range(0, 19) == 0)
          send(ACT_UNUSED, $urandom_range(0, 63), $urandom_range(0, 15), 16'($urandom));
        if ($urandom_range(0, 19) == 0 && n_in < 64)
          send(ACT_ELEM, $urandom_range(n_in, 63), $urandom_range(0, 15), 16'($urandom));
        // occasional overwrite of a weight already in use
        if ($urandom_range(0, 19) == 0)
          send(ACT_WEIGHT, r, $urandom_range(0, n_out - 1), rnd_val());
        send(ACT_ELEM, r, $urandom, big ? rnd_val() : 16'(int'($urandom_range(0, 2047)) - 1024));
      end
    end
    drain();
  endtask

  initial begin
    calm = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = REG_IN_SIZE;
    cfg_data = '0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: single-element rows, extreme values, both activations, then oversize
    run_phase(1, 1, 0, 4, 1, 0);
    run_phase(1, 16, 1, 3, 1, 0);
    run_phase(0, 0, 1, 2, 1, 0);     // zero sizes act as one
    run_phase(127, 31, 0, 1, 0, 1);  // oversize clamps to full shape
    // random phases, mostly small shapes
    for (int p = 0; p < 3; p++)
      run_phase($urandom_range(1, 6), $urandom_range(1, 16), p[0], 3, p[1], 0);
    calm = 1;
    run_phase($urandom_range(2, 5), $urandom_range(1, 16), 1, 3, 1, 0);
    drain();

    if (n_fail == 0)
      $display("PASS dense_layer_relu_gelu_top");
    else
      $display("FAIL dense_layer_relu_gelu_top");
    $finish;
  end
endmodule

/* sim.f */
design/dlrg_pkg.sv
design/dlrg_ctrl.sv
design/dlrg_dp.sv
design/dense_layer_relu_gelu_top.sv
dv/dlrg_checker.sv
dv/tb_top.sv
